// ===== rtl/assert_macros.svh =====
// assertion macros shared by the magnetometer heading rtl
// expects signals named clk and arst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define MH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mh_pkg.sv =====
// package for the magnetometer heading block
// widths, cordic arc table, sequencer states; no dependencies
package mh_pkg;

	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 3;
	localparam int BEARING_W   = 15;
	localparam int SAMPLE_W    = 16;
	localparam int ANGLE_W     = 32;
	localparam int CW          = 20;  // cordic datapath, covers gain of about 1.65
	localparam int TABLE_LEN   = 24;
	localparam int IDX_W       = $clog2(TABLE_LEN);
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_CNT    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int PROD_W      = ANGLE_W + BEARING_W;
	localparam int SUM_W       = BEARING_W + 2;
	localparam int FULL_UNITS  = 23040;
	localparam int BYTES_FULL  = 6;

	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(STEP_CNT - 1);
	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-i), full turn = 2^32
	localparam logic [ANGLE_W-1:0] ARC_TABLE [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORD,
		ST_MUL,
		ST_RND,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_status_t;

endpackage

// ===== rtl/mh_sample_if.sv =====
// input channel: one magnetometer read
// depends on mh_pkg
interface mh_sample_if;
	logic                        valid;
	logic                        ready;
	logic [mh_pkg::BYTE_W-1:0]   x_high;
	logic [mh_pkg::BYTE_W-1:0]   x_low;
	logic [mh_pkg::BYTE_W-1:0]   y_high;
	logic [mh_pkg::BYTE_W-1:0]   y_low;
	logic [mh_pkg::CNT_W-1:0]    bytes_received;

	modport source(output valid, x_high, x_low, y_high, y_low, bytes_received, input ready);
	modport sink(input valid, x_high, x_low, y_high, y_low, bytes_received, output ready);
endinterface

// ===== rtl/mh_heading_if.sv =====
// output channel: one bearing result
// depends on mh_pkg
interface mh_heading_if;
	logic                          valid;
	logic                          ready;
	logic [mh_pkg::BEARING_W-1:0]  bearing;
	logic                          read_error;

	modport source(output valid, bearing, read_error, input ready);
	modport sink(input valid, bearing, read_error, output ready);
endinterface

// ===== rtl/mh_cfg_if.sv =====
// configuration write channel: declination register
// depends on mh_pkg
interface mh_cfg_if;
	logic                                valid;
	logic                                ready;
	logic signed [mh_pkg::BEARING_W-1:0] declination;

	modport source(output valid, declination, input ready);
	modport sink(input valid, declination, output ready);
endinterface

// ===== rtl/mh_cordic.sv =====
// vectoring cordic, one shift-add iteration per cycle
// depends on mh_pkg and assert_macros.svh
`include "assert_macros.svh"

module mh_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [mh_pkg::SAMPLE_W-1:0]  x_in,
	input  logic signed [mh_pkg::SAMPLE_W-1:0]  y_in,
	output mh_pkg::cordic_status_t              status,
	output logic [mh_pkg::ANGLE_W-1:0]          angle
);

	logic signed [mh_pkg::CW-1:0]  x_q, y_q, xs, ys, x_ext, y_ext;
	logic [mh_pkg::ANGLE_W-1:0]    z_q;
	logic [mh_pkg::IDX_W-1:0]      i_q;
	logic                          run_q, done_q, zero_q;

	assign x_ext = mh_pkg::CW'(x_in);
	assign y_ext = mh_pkg::CW'(y_in);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= run_q && (i_q == mh_pkg::LAST_IDX);
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (i_q == mh_pkg::LAST_IDX)
					run_q <= 1'b0;
				else
					i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			// left half plane: rotate by half a turn first
			if (x_in[mh_pkg::SAMPLE_W-1]) begin
				x_q <= -x_ext;
				y_q <= -y_ext;
				z_q <= mh_pkg::HALF_TURN;
			end else begin
				x_q <= x_ext;
				y_q <= y_ext;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (!y_q[mh_pkg::CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + mh_pkg::ARC_TABLE[i_q];
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - mh_pkg::ARC_TABLE[i_q];
			end
		end
	end

	assign status.busy = run_q;
	assign status.done = done_q;
	assign angle       = zero_q ? '0 : z_q;

	`MH_ASSERT_IMPL(a_idx_bound, run_q, i_q <= mh_pkg::LAST_IDX, "cordic index past last step")
	`MH_ASSERT_NEXT(a_last_done, run_q && (i_q == mh_pkg::LAST_IDX), done_q, "no done after last step")
	`MH_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "cordic done held longer than one cycle")

endmodule

// ===== rtl/magnetometer_heading_top.sv =====
// magnetometer heading top level: sequencer, angle scaling, declination wrap
// depends on mh_pkg, the three channel interfaces, mh_cordic, assert_macros.svh
`include "assert_macros.svh"

// Takes one magnetometer read per transaction on sample and returns one bearing
// transaction on heading, in 1/64 degree units from 0 to 23039. A complete read
// (bytes_received equal to six) reaches the output register in these steps after
// its acceptance: the cordic is loaded at the accepting edge, then 16 shift-add
// iterations in the single shared cordic unit (one step per cycle), a state in
// which its done flag is seen, a 32x15 multiply, a rounding step, the
// declination add with wrap, and the output load. The next read can be taken at
// the earliest in the cycle after the output load. A short read goes from
// acceptance through the finish state to the output register with the last good
// bearing and read_error set, and the next read follows in the same way.
// sample.ready is high only while the sequencer is idle; the output register
// lets a finished result wait on heading while the next read is taken, and the
// sequencer holds its own result until that register frees, so a stall on
// heading delays its output load. Declination is a signed 15-bit value in 1/64
// degree; the user must see that it is written on cfg while no read is in
// flight, as the block does not enforce it.

module magnetometer_heading_top (
	input  logic          clk,
	input  logic          arst_n,
	mh_sample_if.sink     sample,
	mh_heading_if.source  heading,
	mh_cfg_if.sink        cfg
);

	mh_pkg::state_t                    state_q, state_d;
	mh_pkg::cordic_status_t            cst;

	logic                              accept, short_read, cordic_start, out_load;
	logic [mh_pkg::ANGLE_W-1:0]        angle;
	logic signed [mh_pkg::SAMPLE_W-1:0] x_sample, y_sample;

	logic signed [mh_pkg::BEARING_W-1:0] decl_q;
	logic [mh_pkg::BEARING_W-1:0]      last_bearing_q, res_q, h_q, out_bearing_q, h_rnd;
	logic [mh_pkg::PROD_W-1:0]         prod_q, rnd_sum;
	logic signed [mh_pkg::SUM_W-1:0]   sum, wrapped;
	logic                              err_q, out_valid_q, out_err_q;

	// byte pairs, msb first
	assign x_sample = {sample.x_high, sample.x_low};
	assign y_sample = {sample.y_high, sample.y_low};

	assign accept     = sample.valid && sample.ready;
	assign short_read = sample.bytes_received != mh_pkg::CNT_W'(mh_pkg::BYTES_FULL);

	mh_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x_in   (x_sample),
		.y_in   (y_sample),
		.status (cst),
		.angle  (angle)
	);

	// binary angle to 1/64 degree, round half up, full circle folds to zero
	assign rnd_sum = prod_q + mh_pkg::PROD_W'(mh_pkg::HALF_TURN);
	assign h_rnd   = rnd_sum[mh_pkg::PROD_W-1:mh_pkg::ANGLE_W];

	// declination add, one correction either way is enough
	assign sum = $signed({2'b00, h_q}) + mh_pkg::SUM_W'(decl_q);
	always_comb begin
		if (sum < 0)
			wrapped = sum + mh_pkg::SUM_W'(mh_pkg::FULL_UNITS);
		else if (sum >= mh_pkg::SUM_W'(mh_pkg::FULL_UNITS))
			wrapped = sum - mh_pkg::SUM_W'(mh_pkg::FULL_UNITS);
		else
			wrapped = sum;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mh_pkg::ST_IDLE: begin
				if (accept)
					state_d = short_read ? mh_pkg::ST_FIN : mh_pkg::ST_CORD;
			end
			mh_pkg::ST_CORD: begin
				if (cst.done)
					state_d = mh_pkg::ST_MUL;
			end
			mh_pkg::ST_MUL: state_d = mh_pkg::ST_RND;
			mh_pkg::ST_RND: state_d = mh_pkg::ST_SUM;
			mh_pkg::ST_SUM: state_d = mh_pkg::ST_FIN;
			mh_pkg::ST_FIN: begin
				if (!out_valid_q || heading.ready)
					state_d = mh_pkg::ST_IDLE;
			end
			default: state_d = mh_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample.ready = 1'b0;
		cordic_start = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			mh_pkg::ST_IDLE: begin
				sample.ready = 1'b1;
				cordic_start = sample.valid && !short_read;
			end
			mh_pkg::ST_FIN: out_load = !out_valid_q || heading.ready;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mh_pkg::ST_IDLE;
			out_valid_q    <= 1'b0;
			decl_q         <= '0;
			last_bearing_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid)
				decl_q <= cfg.declination;
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!err_q)
					last_bearing_q <= res_q;
			end else if (heading.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= short_read;
			res_q <= last_bearing_q;
		end
		if (state_q == mh_pkg::ST_MUL)
			prod_q <= mh_pkg::PROD_W'(angle) * mh_pkg::PROD_W'(mh_pkg::FULL_UNITS);
		if (state_q == mh_pkg::ST_RND)
			h_q <= (h_rnd == mh_pkg::BEARING_W'(mh_pkg::FULL_UNITS)) ? '0 : h_rnd;
		if (state_q == mh_pkg::ST_SUM)
			res_q <= wrapped[mh_pkg::BEARING_W-1:0];
		if (out_load) begin
			out_bearing_q <= res_q;
			out_err_q     <= err_q;
		end
	end

	assign cfg.ready          = 1'b1;
	assign heading.valid      = out_valid_q;
	assign heading.bearing    = out_bearing_q;
	assign heading.read_error = out_err_q;

	`MH_ASSERT_IMPL(a_bearing_range, heading.valid, heading.bearing < mh_pkg::BEARING_W'(mh_pkg::FULL_UNITS), "bearing out of range")
	`MH_ASSERT_IMPL(a_err_repeats, heading.valid && heading.read_error, heading.bearing == last_bearing_q, "short read does not repeat last bearing")
	`MH_ASSERT_IMPL(a_done_in_cord, cst.done, state_q == mh_pkg::ST_CORD, "cordic done outside wait state")
	`MH_ASSERT_NEXT(a_start_busy, cordic_start, cst.busy, "cordic not running after start")

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for magnetometer_heading_top: short reads, cordic bearings, declination wrap
// depends on mh_pkg, mh_sample_if, mh_heading_if, mh_cfg_if and the block rtl
`timescale 1ns / 1ps

module testbench;

	// cycles the sequencer may still need after its last result, per the top level latency
	localparam int SETTLE_CYCLES = 30;
	// cycles with no transaction on any channel before the run is called hung
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_PHASES = 6;
	localparam int READS_PER_PHASE = 142;
	localparam logic [mh_pkg::ANGLE_W-1:0] HALF_TURN_ANGLE = 32'h8000_0000;

	// atan(2^-i) with a full turn of 2^32, kept apart from the rtl table
	localparam logic [31:0] ATAN_TURNS [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [mh_pkg::BYTE_W-1:0] x_high;
		logic [mh_pkg::BYTE_W-1:0] x_low;
		logic [mh_pkg::BYTE_W-1:0] y_high;
		logic [mh_pkg::BYTE_W-1:0] y_low;
		logic [mh_pkg::CNT_W-1:0]  bytes_received;
	} compass_read_t;

	typedef struct packed {
		logic [mh_pkg::BEARING_W-1:0] bearing;
		logic                         read_error;
	} heading_t;

	logic clk;
	logic arst_n;

	mh_sample_if  sample_ch();
	mh_heading_if heading_ch();
	mh_cfg_if     cfg_ch();

	magnetometer_heading_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.heading (heading_ch),
		.cfg     (cfg_ch)
	);

	// bench copy of the block state and its one register
	logic [mh_pkg::BEARING_W-1:0] last_bearing;
	int                           declination_now;

	// bearings owed by the block, oldest first
	heading_t pending_headings [$];

	int mismatch_count;
	int checked_count;
	int complete_reads;
	int short_reads;
	int declination_writes;

	// sender burst bookkeeping
	int  burst_left;
	bit  steady_sender;

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// expected bearing for one accepted read; also advances the bench state
	function automatic heading_t advance_compass(compass_read_t r);
		heading_t                    res;
		longint                      x, y, xs, ys;
		logic [mh_pkg::ANGLE_W-1:0]  z;
		logic [63:0]                 scaled;
		int                          h, s;
		// anything but a full six-byte read repeats the last bearing
		if (r.bytes_received != mh_pkg::CNT_W'(mh_pkg::BYTES_FULL)) begin
			res.bearing    = last_bearing;
			res.read_error = 1'b1;
			return res;
		end
		x = longint'($signed({r.x_high, r.x_low}));
		y = longint'($signed({r.y_high, r.y_low}));
		z = '0;
		// zero vector keeps a heading of zero
		if (x != 0 || y != 0) begin
			// left half plane: turn by half a circle first
			if (x < 0) begin
				x = -x;
				y = -y;
				z = HALF_TURN_ANGLE;
			end
			for (int i = 0; i < mh_pkg::STEP_CNT; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_TURNS[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_TURNS[i];
				end
			end
		end
		// binary angle to 1/64 degree, round half up
		scaled = {32'd0, z} * 64'(mh_pkg::FULL_UNITS) + 64'h8000_0000;
		h = int'(scaled[63:32]);
		if (h >= mh_pkg::FULL_UNITS)
			h -= mh_pkg::FULL_UNITS;
		// declination can push the sum out either side of one turn
		s = h + declination_now;
		if (s < 0)
			s += mh_pkg::FULL_UNITS;
		if (s >= mh_pkg::FULL_UNITS)
			s -= mh_pkg::FULL_UNITS;
		last_bearing   = mh_pkg::BEARING_W'(s);
		res.bearing    = last_bearing;
		res.read_error = 1'b0;
		return res;
	endfunction

	function automatic compass_read_t make_read(logic [15:0] x, logic [15:0] y,
			logic [mh_pkg::CNT_W-1:0] count);
		compass_read_t r;
		r.x_high         = x[15:8];
		r.x_low          = x[7:0];
		r.y_high         = y[15:8];
		r.y_low          = y[7:0];
		r.bytes_received = count;
		return r;
	endfunction

	// random axis value with a bias toward corners, small vectors and axes
	function automatic logic [15:0] random_axis();
		logic [15:0] corners [5];
		int          shape;
		corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
		shape   = $urandom_range(0, 9);
		if (shape <= 5)
			return 16'($urandom);
		if (shape <= 7)
			return 16'($urandom_range(0, 16) - 8);
		return corners[$urandom_range(0, 4)];
	endfunction

	function automatic logic [mh_pkg::CNT_W-1:0] short_count();
		int n;
		n = $urandom_range(0, 6);
		if (n == mh_pkg::BYTES_FULL)
			n = 7;
		return mh_pkg::CNT_W'(n);
	endfunction

	// one read transaction on the sample channel, with burst gaps ahead of it
	task automatic send_read(compass_read_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				sample_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sample_ch.x_high         = r.x_high;
		sample_ch.x_low          = r.x_low;
		sample_ch.y_high         = r.y_high;
		sample_ch.y_low          = r.y_low;
		sample_ch.bytes_received = r.bytes_received;
		sample_ch.valid          = 1'b1;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		if (r.bytes_received == mh_pkg::CNT_W'(mh_pkg::BYTES_FULL))
			complete_reads++;
		else
			short_reads++;
		pending_headings.push_back(advance_compass(r));
	endtask

	// stop sending and let every owed bearing come back, then let the sequencer settle
	task automatic drain_block();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		burst_left = 0;
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// declination register write, only with the block idle
	task automatic write_declination(int value);
		drain_block();
		@(negedge clk);
		cfg_ch.declination = mh_pkg::BEARING_W'(value);
		cfg_ch.valid       = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		declination_now = int'($signed(mh_pkg::BEARING_W'(value)));
		declination_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s at result %0d: got %0d, expected %0d (t=%0t)",
			field, checked_count, got, want, $realtime);
		mismatch_count++;
	endtask

	// result side stalls in modes that are redrawn at random:
	// always ready, coin flips, or long holds now and then
	initial begin
		int mode;
		int mode_left;
		int hold;
		heading_ch.ready = 1'b0;
		mode      = 0;
		mode_left = 0;
		hold      = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 250);
			end
			mode_left--;
			if (hold > 0) begin
				hold--;
				heading_ch.ready = 1'b0;
			end else begin
				case (mode)
					0: begin
						heading_ch.ready = 1'b1;
					end
					1: begin
						heading_ch.ready = 1'($urandom_range(0, 1));
					end
					default: begin
						if ($urandom_range(0, 5) == 0) begin
							hold = $urandom_range(5, 40);
							heading_ch.ready = 1'b0;
						end else begin
							heading_ch.ready = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// every bearing transaction is checked against the oldest owed result
	always @(posedge clk) begin
		heading_t want;
		if (arst_n && heading_ch.valid && heading_ch.ready) begin
			if (pending_headings.size() == 0) begin
				$display("unexpected bearing transaction: bearing %0d read_error %0d (t=%0t)",
					heading_ch.bearing, heading_ch.read_error, $realtime);
				mismatch_count++;
			end else begin
				want = pending_headings.pop_front();
				if (heading_ch.bearing !== want.bearing)
					report_mismatch("bearing", int'(heading_ch.bearing), int'(want.bearing));
				if (heading_ch.read_error !== want.read_error)
					report_mismatch("read_error", int'(heading_ch.read_error),
						int'(want.read_error));
			end
			checked_count++;
		end
	end

	// hang detector: any transaction on any channel resets the count
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (heading_ch.valid && heading_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles, %0d bearings still owed",
			IDLE_LIMIT, pending_headings.size());
		$display("testbench: FAIL");
		$finish;
	end

	// short reads first, so the repeated bearing is the reset value, then every count
	// other than six including seven, with byte patterns that must be ignored
	task automatic test_short_reads();
		send_read(make_read(16'hFFFF, 16'hFFFF, 3'd0));
		send_read(make_read(16'h0000, 16'h0000, 3'd1));
		send_read(make_read(16'h7FFF, 16'h8000, 3'd2));
		send_read(make_read(16'h8000, 16'h7FFF, 3'd3));
		send_read(make_read(16'hA5A5, 16'h5A5A, 3'd4));
		send_read(make_read(16'h5A5A, 16'hA5A5, 3'd5));
		send_read(make_read(16'h1234, 16'hFEDC, 3'd7));
	endtask

	// axis and corner vectors with no declination
	task automatic test_axis_extremes();
		// zero vector gives heading zero
		send_read(make_read(16'h0000, 16'h0000, 3'd6));
		send_read(make_read(16'h7FFF, 16'h0000, 3'd6));
		send_read(make_read(16'h0000, 16'h7FFF, 3'd6));
		// most negative x: rotated by a half turn before the iterations
		send_read(make_read(16'h8000, 16'h0000, 3'd6));
		send_read(make_read(16'h0000, 16'h8000, 3'd6));
		send_read(make_read(16'h8000, 16'h8000, 3'd6));
		// just below a full turn, rounding lands on 360 and wraps to zero
		send_read(make_read(16'h7FFF, 16'hFFFF, 3'd6));
		send_read(make_read(16'hFFFF, 16'h0000, 3'd6));
		send_read(make_read(16'h8000, 16'h7FFF, 3'd6));
		// bearing from the last good read comes back
		send_read(make_read(16'h0000, 16'h0000, 3'd7));
	endtask

	// register extremes, with headings chosen to wrap up and down
	task automatic test_declination_wrap();
		write_declination(16383);
		send_read(make_read(16'h7FFF, 16'hE000, 3'd6));
		send_read(make_read(16'h4000, 16'h4000, 3'd5));
		write_declination(-16384);
		send_read(make_read(16'h7FFF, 16'h0000, 3'd6));
		write_declination(11520);
		send_read(make_read(16'h8000, 16'h0000, 3'd6));
		write_declination(-11520);
		send_read(make_read(16'h7FFF, 16'h0000, 3'd6));
		send_read(make_read(16'h0000, 16'h8000, 3'd6));
	endtask

	// random reads over several declination settings; most are complete reads
	task automatic test_random_reads();
		int            setting;
		compass_read_t r;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: setting = 0;
				1: setting = 16383;
				2: setting = -16384;
				3: setting = int'($signed(mh_pkg::BEARING_W'($urandom)));
				default: setting = $urandom_range(0, 2 * 11520) - 11520;
			endcase
			write_declination(setting);
			steady_sender = (phase % 3 == 1);
			for (int n = 0; n < READS_PER_PHASE; n++) begin
				if ($urandom_range(0, 4) == 0)
					r = make_read(16'($urandom), 16'($urandom), short_count());
				else
					r = make_read(random_axis(), random_axis(),
						mh_pkg::CNT_W'(mh_pkg::BYTES_FULL));
				send_read(r);
			end
		end
		steady_sender = 1'b0;
	endtask

	initial begin
		// every input known from time zero
		arst_n                   = 1'b0;
		sample_ch.valid          = 1'b0;
		sample_ch.x_high         = '0;
		sample_ch.x_low          = '0;
		sample_ch.y_high         = '0;
		sample_ch.y_low          = '0;
		sample_ch.bytes_received = '0;
		cfg_ch.valid             = 1'b0;
		cfg_ch.declination       = '0;

		last_bearing       = '0;
		declination_now    = 0;
		mismatch_count     = 0;
		checked_count      = 0;
		complete_reads     = 0;
		short_reads        = 0;
		declination_writes = 0;
		burst_left         = 0;
		steady_sender      = 1'b0;

		// one reset at the start, released away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_reads();
		write_declination(0);
		test_axis_extremes();
		test_declination_wrap();
		test_random_reads();

		drain_block();
		$display("covered %0d complete reads and %0d short reads over %0d declination writes",
			complete_reads, short_reads, declination_writes);
		$display("checked %0d bearing transactions, %0d mismatches",
			checked_count, mismatch_count);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mh_pkg.sv
rtl/mh_sample_if.sv
rtl/mh_heading_if.sv
rtl/mh_cfg_if.sv
rtl/mh_cordic.sv
rtl/magnetometer_heading_top.sv
bench/testbench.sv
